FILE: rtl/gwe_pkg.sv
// shared types, sizes and codes of the graph walk engine
package gwe_pkg;

  localparam int NUM_VTX  = 16;
  localparam int NUM_EDGE = 64;

  localparam int VIDX_W = $clog2(NUM_VTX);
  localparam int VCNT_W = $clog2(NUM_VTX + 1);
  localparam int EIDX_W = $clog2(NUM_EDGE);
  localparam int ENT_W  = $clog2(NUM_EDGE + 1);
  localparam int LAB_W  = 8;
  localparam int DEG_W  = 7;

  localparam logic [ENT_W-1:0] LIST_END = ENT_W'(NUM_EDGE);

  typedef enum logic [2:0] {
    REQ_ADD_V = 3'd0,
    REQ_ADD_E = 3'd1,
    REQ_DEG   = 3'd2,
    REQ_BFS   = 3'd3,
    REQ_DFS   = 3'd4,
    REQ_PATH  = 3'd5,
    REQ_CYCLE = 3'd6,
    REQ_NONE  = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // control states of the top level
  typedef enum logic [4:0] {
    S_IDLE, S_LK_RD, S_LK_CMP, S_DISP,
    S_E_WRA, S_E_RDB, S_E_WRB,
    S_D_HD, S_D_CHK, S_D_EW,
    S_B_POP, S_B_POPW, S_B_LAB, S_B_HD, S_B_CHK, S_B_EW,
    S_K_TOP, S_K_TOPW, S_K_EW, S_K_PUSH, S_K_LAB
  } state_e;

  typedef struct packed {
    logic [VIDX_W-1:0] tgt;
    logic [ENT_W-1:0]  link;
  } edge_t;

  typedef struct packed {
    logic [VIDX_W-1:0] vtx;
    logic [ENT_W-1:0]  ent;
    logic [VIDX_W-1:0] par;
    logic              hp;
  } frame_t;

  typedef struct packed {
    status_e           st;
    logic [LAB_W-1:0]  lab;
    logic [DEG_W-1:0]  deg;
    logic              flag;
    logic              last;
  } res_t;

  function automatic res_t mk_res(status_e st, logic [LAB_W-1:0] lab,
                                  logic [DEG_W-1:0] deg, logic flag, logic last);
    res_t r;
    r.st   = st;
    r.lab  = lab;
    r.deg  = deg;
    r.flag = flag;
    r.last = last;
    return r;
  endfunction

endpackage

FILE: rtl/gwe_ram.sv
// generic single-port ram with registered read
module gwe_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic [$clog2(D)-1:0] addr_i,
  input  logic                 we_i,
  input  logic [W-1:0]         wdata_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: rtl/graph_walk_engine.sv
// graph walk engine top level: adjacency-list graph with bfs, dfs, path and cycle requests
//
//  channel  | handshake                     | beat
//  ---------+-------------------------------+------------------------------------------
//  request  | start, busy                   | req_type_i, label_a_i, label_b_i
//  result   | result_strobe_o (no stall)    | status_o, vertex_label_o, degree_count_o,
//           |                               | answer_flag_o, last_o
//
// one request at a time; busy drops in the cycle that carries the final result beat
// add vertex keeps busy low and its beat comes out in the cycle after the accept
// other requests first scan labels newest first, a read and a compare per vertex, then walk the
//   single-port memories: degree, bfs and path check and read each adjacency entry, while dfs and
//   cycle check read the top frame, read its entry and write the advanced frame back
// the label, head, edge and stack memories are each read at most once per cycle
// reset clears counts, visited marks and control; memory contents stay undefined
// result beats cannot be held off, each is on the ports for exactly one cycle
module graph_walk_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  req_type_i,
  input  logic [gwe_pkg::LAB_W-1:0]   label_a_i,
  input  logic [gwe_pkg::LAB_W-1:0]   label_b_i,
  output logic                        result_strobe_o,
  output logic [1:0]                  status_o,
  output logic [gwe_pkg::LAB_W-1:0]   vertex_label_o,
  output logic [gwe_pkg::DEG_W-1:0]   degree_count_o,
  output logic                        answer_flag_o,
  output logic                        last_o
);

  localparam int VIDX_W = gwe_pkg::VIDX_W;
  localparam int VCNT_W = gwe_pkg::VCNT_W;
  localparam int EIDX_W = gwe_pkg::EIDX_W;
  localparam int ENT_W  = gwe_pkg::ENT_W;
  localparam int LAB_W  = gwe_pkg::LAB_W;
  localparam int DEG_W  = gwe_pkg::DEG_W;
  localparam int NV     = gwe_pkg::NUM_VTX;
  localparam int NE     = gwe_pkg::NUM_EDGE;
  localparam int EDGE_W  = $bits(gwe_pkg::edge_t);
  localparam int FRAME_W = $bits(gwe_pkg::frame_t);

  gwe_pkg::state_e state_q, state_d;

  // control state
  logic [VCNT_W-1:0] vcnt_q, vcnt_d;
  logic [ENT_W-1:0]  ecnt_q, ecnt_d;
  logic [NV-1:0]     vis_q, vis_d;
  logic [VCNT_W-1:0] sp_q, sp_d;      // dfs stack depth, also bfs write count
  logic [VCNT_W-1:0] qrd_q, qrd_d;
  logic [VCNT_W-1:0] lk_idx_q, lk_idx_d;
  logic              lk_2nd_q, lk_2nd_d;
  logic              pend_v_q, pend_v_d;
  logic              res_v_q, res_v_d;

  // payload
  gwe_pkg::req_e     req_q, req_d;
  logic [LAB_W-1:0]  la_q, la_d, lb_q, lb_d;
  logic [VIDX_W-1:0] a_q, a_d, b_q, b_d, t_q, t_d, par_q, par_d;
  logic              hp_q, hp_d;
  logic [ENT_W-1:0]  e_q, e_d, cnt_q, cnt_d;
  gwe_pkg::frame_t   fr_q, fr_d;
  logic [LAB_W-1:0]  pend_lab_q, pend_lab_d;
  gwe_pkg::res_t     res_q, res_d;

  // memory ports
  logic [VIDX_W-1:0] lab_addr, head_addr;
  logic              lab_we, head_we, edg_we, wlk_we;
  logic [LAB_W-1:0]  lab_wd, lab_rd;
  logic [ENT_W-1:0]  head_wd, head_rd;
  logic [EIDX_W-1:0] edg_addr;
  gwe_pkg::edge_t    edg_wd, edg_rd;
  logic [VIDX_W-1:0] wlk_addr;
  gwe_pkg::frame_t   wlk_wd, wlk_rd;

  gwe_ram #(.W(LAB_W), .D(NV)) u_lab_ram (
    .clk_i(clk_i), .addr_i(lab_addr), .we_i(lab_we), .wdata_i(lab_wd), .rdata_o(lab_rd)
  );
  gwe_ram #(.W(ENT_W), .D(NV)) u_head_ram (
    .clk_i(clk_i), .addr_i(head_addr), .we_i(head_we), .wdata_i(head_wd), .rdata_o(head_rd)
  );
  gwe_ram #(.W(EDGE_W), .D(NE)) u_edge_ram (
    .clk_i(clk_i), .addr_i(edg_addr), .we_i(edg_we), .wdata_i(edg_wd), .rdata_o(edg_rd)
  );
  // dfs frames, or the bfs queue in the vertex field
  gwe_ram #(.W(FRAME_W), .D(NV)) u_walk_ram (
    .clk_i(clk_i), .addr_i(wlk_addr), .we_i(wlk_we), .wdata_i(wlk_wd), .rdata_o(wlk_rd)
  );

  logic [VCNT_W-1:0] lk_dec, sp_dec;
  logic [ENT_W-1:0]  ecnt_inc;
  logic [ENT_W:0]    ecnt_need;
  logic [LAB_W-1:0]  lk_key;
  logic [DEG_W-1:0]  deg_sat;

  assign lk_dec    = lk_idx_q - VCNT_W'(1);
  assign sp_dec    = sp_q - VCNT_W'(1);
  assign ecnt_inc  = ecnt_q + ENT_W'(1);
  assign ecnt_need = {1'b0, ecnt_q} + (ENT_W+1)'(2);
  assign lk_key    = lk_2nd_q ? lb_q : la_q;
  assign deg_sat   = (cnt_q > ENT_W'((1 << DEG_W) - 1)) ? DEG_W'((1 << DEG_W) - 1)
                                                         : DEG_W'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gwe_pkg::S_IDLE;
      vcnt_q   <= '0;
      ecnt_q   <= '0;
      vis_q    <= '0;
      sp_q     <= '0;
      qrd_q    <= '0;
      lk_idx_q <= '0;
      lk_2nd_q <= 1'b0;
      pend_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      vcnt_q   <= vcnt_d;
      ecnt_q   <= ecnt_d;
      vis_q    <= vis_d;
      sp_q     <= sp_d;
      qrd_q    <= qrd_d;
      lk_idx_q <= lk_idx_d;
      lk_2nd_q <= lk_2nd_d;
      pend_v_q <= pend_v_d;
      res_v_q  <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    la_q       <= la_d;
    lb_q       <= lb_d;
    a_q        <= a_d;
    b_q        <= b_d;
    t_q        <= t_d;
    par_q      <= par_d;
    hp_q       <= hp_d;
    e_q        <= e_d;
    cnt_q      <= cnt_d;
    fr_q       <= fr_d;
    pend_lab_q <= pend_lab_d;
    res_q      <= res_d;
  end

  always_comb begin
    state_d    = state_q;
    vcnt_d     = vcnt_q;
    ecnt_d     = ecnt_q;
    vis_d      = vis_q;
    sp_d       = sp_q;
    qrd_d      = qrd_q;
    lk_idx_d   = lk_idx_q;
    lk_2nd_d   = lk_2nd_q;
    pend_v_d   = pend_v_q;
    res_v_d    = 1'b0;
    req_d      = req_q;
    la_d       = la_q;
    lb_d       = lb_q;
    a_d        = a_q;
    b_d        = b_q;
    t_d        = t_q;
    par_d      = par_q;
    hp_d       = hp_q;
    e_d        = e_q;
    cnt_d      = cnt_q;
    fr_d       = fr_q;
    pend_lab_d = pend_lab_q;
    res_d      = res_q;

    lab_addr  = '0;
    lab_we    = 1'b0;
    lab_wd    = label_a_i;
    head_addr = '0;
    head_we   = 1'b0;
    head_wd   = gwe_pkg::LIST_END;
    edg_addr  = '0;
    edg_we    = 1'b0;
    edg_wd    = '0;
    wlk_addr  = '0;
    wlk_we    = 1'b0;
    wlk_wd    = '0;

    unique case (state_q)
      gwe_pkg::S_IDLE: begin
        if (start) begin
          req_d    = gwe_pkg::req_e'(req_type_i);
          la_d     = label_a_i;
          lb_d     = label_b_i;
          lk_idx_d = vcnt_q;
          lk_2nd_d = 1'b0;
          if (gwe_pkg::req_e'(req_type_i) == gwe_pkg::REQ_ADD_V) begin
            res_v_d = 1'b1;
            if (vcnt_q == VCNT_W'(NV)) begin
              res_d = gwe_pkg::mk_res(gwe_pkg::ST_FULL, '0, '0, 1'b0, 1'b1);
            end else begin
              lab_addr  = vcnt_q[VIDX_W-1:0];
              lab_we    = 1'b1;
              head_addr = vcnt_q[VIDX_W-1:0];
              head_we   = 1'b1;
              vcnt_d    = vcnt_q + VCNT_W'(1);
              res_d     = gwe_pkg::mk_res(gwe_pkg::ST_OK, '0, '0, 1'b0, 1'b1);
            end
          end else if (gwe_pkg::req_e'(req_type_i) != gwe_pkg::REQ_NONE) begin
            state_d = gwe_pkg::S_LK_RD;
          end
        end
      end

      // newest-first label scan
      gwe_pkg::S_LK_RD: begin
        if (lk_idx_q == '0) begin
          res_v_d = 1'b1;
          res_d   = gwe_pkg::mk_res(gwe_pkg::ST_NOT_FOUND, '0, '0, 1'b0, 1'b1);
          state_d = gwe_pkg::S_IDLE;
        end else begin
          lab_addr = lk_dec[VIDX_W-1:0];
          state_d  = gwe_pkg::S_LK_CMP;
        end
      end

      gwe_pkg::S_LK_CMP: begin
        if (lab_rd == lk_key) begin
          if (!lk_2nd_q) begin
            a_d = lk_dec[VIDX_W-1:0];
            if (req_q == gwe_pkg::REQ_ADD_E || req_q == gwe_pkg::REQ_PATH) begin
              lk_2nd_d = 1'b1;
              lk_idx_d = vcnt_q;
              state_d  = gwe_pkg::S_LK_RD;
            end else begin
              state_d = gwe_pkg::S_DISP;
            end
          end else begin
            b_d     = lk_dec[VIDX_W-1:0];
            state_d = gwe_pkg::S_DISP;
          end
        end else begin
          lk_idx_d = lk_dec;
          state_d  = gwe_pkg::S_LK_RD;
        end
      end

      gwe_pkg::S_DISP: begin
        pend_v_d = 1'b0;
        priority case (req_q)
          gwe_pkg::REQ_ADD_E: begin
            if (ecnt_need > (ENT_W+1)'(NE)) begin
              res_v_d = 1'b1;
              res_d   = gwe_pkg::mk_res(gwe_pkg::ST_FULL, '0, '0, 1'b0, 1'b1);
              state_d = gwe_pkg::S_IDLE;
            end else begin
              head_addr = a_q;
              state_d   = gwe_pkg::S_E_WRA;
            end
          end
          gwe_pkg::REQ_DEG: begin
            head_addr = a_q;
            state_d   = gwe_pkg::S_D_HD;
          end
          gwe_pkg::REQ_BFS, gwe_pkg::REQ_PATH: begin
            vis_d        = '0;
            vis_d[a_q]   = 1'b1;
            wlk_addr     = '0;
            wlk_we       = 1'b1;
            wlk_wd.vtx   = a_q;
            qrd_d        = '0;
            sp_d         = VCNT_W'(1);
            state_d      = gwe_pkg::S_B_POP;
          end
          gwe_pkg::REQ_DFS, gwe_pkg::REQ_CYCLE: begin
            vis_d     = '0;
            sp_d      = '0;
            t_d       = a_q;
            par_d     = '0;
            hp_d      = 1'b0;
            head_addr = a_q;
            state_d   = gwe_pkg::S_K_PUSH;
          end
          default: state_d = gwe_pkg::S_IDLE;
        endcase
      end

      // edge insert: both entries go to the heads of their lists
      gwe_pkg::S_E_WRA: begin
        edg_addr  = ecnt_q[EIDX_W-1:0];
        edg_we    = 1'b1;
        edg_wd    = '{tgt: b_q, link: head_rd};
        head_addr = a_q;
        head_we   = 1'b1;
        head_wd   = ecnt_q;
        state_d   = gwe_pkg::S_E_RDB;
      end

      gwe_pkg::S_E_RDB: begin
        head_addr = b_q;
        state_d   = gwe_pkg::S_E_WRB;
      end

      gwe_pkg::S_E_WRB: begin
        edg_addr  = ecnt_inc[EIDX_W-1:0];
        edg_we    = 1'b1;
        edg_wd    = '{tgt: a_q, link: head_rd};
        head_addr = b_q;
        head_we   = 1'b1;
        head_wd   = ecnt_inc;
        ecnt_d    = ecnt_q + ENT_W'(2);
        res_v_d   = 1'b1;
        res_d     = gwe_pkg::mk_res(gwe_pkg::ST_OK, '0, '0, 1'b0, 1'b1);
        state_d   = gwe_pkg::S_IDLE;
      end

      // degree: count list entries
      gwe_pkg::S_D_HD: begin
        e_d     = head_rd;
        cnt_d   = '0;
        state_d = gwe_pkg::S_D_CHK;
      end

      gwe_pkg::S_D_CHK: begin
        if (e_q < ecnt_q) begin
          edg_addr = e_q[EIDX_W-1:0];
          cnt_d    = cnt_q + ENT_W'(1);
          state_d  = gwe_pkg::S_D_EW;
        end else begin
          res_v_d = 1'b1;
          res_d   = gwe_pkg::mk_res(gwe_pkg::ST_OK, '0, deg_sat, 1'b0, 1'b1);
          state_d = gwe_pkg::S_IDLE;
        end
      end

      gwe_pkg::S_D_EW: begin
        e_d     = edg_rd.link;
        state_d = gwe_pkg::S_D_CHK;
      end

      // breadth-first: queue lives in the walk ram
      gwe_pkg::S_B_POP: begin
        if (qrd_q < sp_q) begin
          wlk_addr = qrd_q[VIDX_W-1:0];
          qrd_d    = qrd_q + VCNT_W'(1);
          state_d  = gwe_pkg::S_B_POPW;
        end else begin
          res_v_d  = 1'b1;
          pend_v_d = 1'b0;
          if (req_q == gwe_pkg::REQ_BFS) begin
            res_d = gwe_pkg::mk_res(gwe_pkg::ST_OK, pend_lab_q, '0, 1'b0, 1'b1);
          end else begin
            res_d = gwe_pkg::mk_res(gwe_pkg::ST_OK, '0, '0, 1'b0, 1'b1);
          end
          state_d = gwe_pkg::S_IDLE;
        end
      end

      gwe_pkg::S_B_POPW: begin
        t_d = wlk_rd.vtx;
        if (req_q == gwe_pkg::REQ_BFS) begin
          lab_addr = wlk_rd.vtx;
          state_d  = gwe_pkg::S_B_LAB;
        end else if (wlk_rd.vtx == b_q) begin
          res_v_d = 1'b1;
          res_d   = gwe_pkg::mk_res(gwe_pkg::ST_OK, '0, '0, 1'b1, 1'b1);
          state_d = gwe_pkg::S_IDLE;
        end else begin
          head_addr = wlk_rd.vtx;
          state_d   = gwe_pkg::S_B_HD;
        end
      end

      gwe_pkg::S_B_LAB: begin
        // hold one label back so the final beat can carry last
        if (pend_v_q) begin
          res_v_d = 1'b1;
          res_d   = gwe_pkg::mk_res(gwe_pkg::ST_OK, pend_lab_q, '0, 1'b0, 1'b0);
        end
        pend_v_d   = 1'b1;
        pend_lab_d = lab_rd;
        head_addr  = t_q;
        state_d    = gwe_pkg::S_B_HD;
      end

      gwe_pkg::S_B_HD: begin
        e_d     = head_rd;
        state_d = gwe_pkg::S_B_CHK;
      end

      gwe_pkg::S_B_CHK: begin
        if (e_q < ecnt_q) begin
          edg_addr = e_q[EIDX_W-1:0];
          state_d  = gwe_pkg::S_B_EW;
        end else begin
          state_d = gwe_pkg::S_B_POP;
        end
      end

      gwe_pkg::S_B_EW: begin
        if (VCNT_W'(edg_rd.tgt) < vcnt_q && !vis_q[edg_rd.tgt] && sp_q < VCNT_W'(NV)) begin
          vis_d[edg_rd.tgt] = 1'b1;
          wlk_addr          = sp_q[VIDX_W-1:0];
          wlk_we            = 1'b1;
          wlk_wd.vtx        = edg_rd.tgt;
          sp_d              = sp_q + VCNT_W'(1);
        end
        e_d     = edg_rd.link;
        state_d = gwe_pkg::S_B_CHK;
      end

      // depth-first: explicit frame stack in the walk ram
      gwe_pkg::S_K_PUSH: begin
        wlk_addr  = sp_q[VIDX_W-1:0];
        wlk_we    = 1'b1;
        wlk_wd    = '{vtx: t_q, ent: head_rd, par: par_q, hp: hp_q};
        vis_d[t_q] = 1'b1;
        sp_d      = sp_q + VCNT_W'(1);
        if (req_q == gwe_pkg::REQ_DFS) begin
          lab_addr = t_q;
          state_d  = gwe_pkg::S_K_LAB;
        end else begin
          state_d = gwe_pkg::S_K_TOP;
        end
      end

      gwe_pkg::S_K_LAB: begin
        if (pend_v_q) begin
          res_v_d = 1'b1;
          res_d   = gwe_pkg::mk_res(gwe_pkg::ST_OK, pend_lab_q, '0, 1'b0, 1'b0);
        end
        pend_v_d   = 1'b1;
        pend_lab_d = lab_rd;
        state_d    = gwe_pkg::S_K_TOP;
      end

      gwe_pkg::S_K_TOP: begin
        if (sp_q == '0) begin
          res_v_d  = 1'b1;
          pend_v_d = 1'b0;
          if (req_q == gwe_pkg::REQ_DFS) begin
            res_d = gwe_pkg::mk_res(gwe_pkg::ST_OK, pend_lab_q, '0, 1'b0, 1'b1);
          end else begin
            res_d = gwe_pkg::mk_res(gwe_pkg::ST_OK, '0, '0, 1'b0, 1'b1);
          end
          state_d = gwe_pkg::S_IDLE;
        end else begin
          wlk_addr = sp_dec[VIDX_W-1:0];
          state_d  = gwe_pkg::S_K_TOPW;
        end
      end

      gwe_pkg::S_K_TOPW: begin
        fr_d = wlk_rd;
        if (wlk_rd.ent < ecnt_q) begin
          edg_addr = wlk_rd.ent[EIDX_W-1:0];
          state_d  = gwe_pkg::S_K_EW;
        end else begin
          sp_d    = sp_dec;
          state_d = gwe_pkg::S_K_TOP;
        end
      end

      gwe_pkg::S_K_EW: begin
        // advance the top frame past this entry
        wlk_addr = sp_dec[VIDX_W-1:0];
        wlk_we   = 1'b1;
        wlk_wd   = '{vtx: fr_q.vtx, ent: edg_rd.link, par: fr_q.par, hp: fr_q.hp};
        state_d  = gwe_pkg::S_K_TOP;
        if (VCNT_W'(edg_rd.tgt) < vcnt_q) begin
          if (!vis_q[edg_rd.tgt]) begin
            if (sp_q < VCNT_W'(NV)) begin
              t_d       = edg_rd.tgt;
              par_d     = fr_q.vtx;
              hp_d      = 1'b1;
              head_addr = edg_rd.tgt;
              state_d   = gwe_pkg::S_K_PUSH;
            end
          end else if (req_q == gwe_pkg::REQ_CYCLE && !(fr_q.hp && fr_q.par == edg_rd.tgt)) begin
            res_v_d = 1'b1;
            res_d   = gwe_pkg::mk_res(gwe_pkg::ST_OK, '0, '0, 1'b1, 1'b1);
            state_d = gwe_pkg::S_IDLE;
          end
        end
      end

      default: state_d = gwe_pkg::S_IDLE;
    endcase
  end

  assign busy            = (state_q != gwe_pkg::S_IDLE);
  assign result_strobe_o = res_v_q;
  assign status_o        = res_q.st;
  assign vertex_label_o  = res_q.lab;
  assign degree_count_o  = res_q.deg;
  assign answer_flag_o   = res_q.flag;
  assign last_o          = res_q.last;

endmodule

FILE: rtl/gwe_chk.sv
// port-level checks of the graph walk engine, bound to the top level
module gwe_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic [2:0]                req_type_i,
  input logic                      result_strobe_o,
  input logic [1:0]                status_o,
  input logic                      answer_flag_o,
  input logic                      last_o
);

  // an accepted request either answers at once or keeps the engine busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_type_i != gwe_pkg::REQ_NONE) |=> (busy || result_strobe_o))
    else $error("accepted request neither answered nor started");

  // error beats always end the request
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && status_o != gwe_pkg::ST_OK) |-> last_o)
    else $error("error result not marked last");

  // a set flag is a single ok answer
  a_flag_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && answer_flag_o) |-> (last_o && status_o == gwe_pkg::ST_OK))
    else $error("flag result malformed");

  // no beat with an undefined status
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> (status_o == gwe_pkg::ST_OK || status_o == gwe_pkg::ST_NOT_FOUND ||
                         status_o == gwe_pkg::ST_FULL))
    else $error("undefined status code");

endmodule

bind graph_walk_engine gwe_chk u_gwe_chk (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .start(start),
  .busy(busy),
  .req_type_i(req_type_i),
  .result_strobe_o(result_strobe_o),
  .status_o(status_o),
  .answer_flag_o(answer_flag_o),
  .last_o(last_o)
);
